### hdl/analog_keypad_decoder_top_defines.svh
// assertion macros shared by the keypad decoder rtl
`ifndef ANALOG_KEYPAD_DECODER_TOP_DEFINES_SVH
`define ANALOG_KEYPAD_DECODER_TOP_DEFINES_SVH

// same-cycle implication, checked on every rising clock edge out of reset
`define AKD_ASSERT_SAME(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error(msg);

// next-cycle implication, checked on every rising clock edge out of reset
`define AKD_ASSERT_NEXT(label, ante, cons, msg) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error(msg);

`endif

### hdl/akd_pkg.sv
// widths, reset values and register indexes of the analog keypad decoder
package akd_pkg;

    // field widths
    localparam int SAMPLE_BITS = 10;
    localparam int STEP_W      = 10;
    localparam int BUTTON_W    = 6;
    localparam int HOLD_W      = 16;
    localparam int TIME_W      = 32;

    // divider sizing: dividend is sample plus half the step
    localparam int DIVIDEND_W  = ((SAMPLE_BITS > STEP_W) ? SAMPLE_BITS : STEP_W) + 1;
    localparam int CNT_W       = $clog2(DIVIDEND_W + 1);

    // configuration port
    localparam int ADDR_W      = 4;
    localparam int DATA_W      = 32;
    localparam int REG_IDX_W   = 2;

    localparam logic [REG_IDX_W-1:0] REG_CONNECTED = 2'd0;
    localparam logic [REG_IDX_W-1:0] REG_STEP      = 2'd1;
    localparam logic [REG_IDX_W-1:0] REG_COUNT     = 2'd2;
    localparam logic [REG_IDX_W-1:0] REG_HOLDOFF   = 2'd3;

    // register reset values
    localparam logic [STEP_W-1:0]   STEP_RESET    = 10'd1;
    localparam logic [HOLD_W-1:0]   HOLDOFF_RESET = 16'd50;

endpackage

### hdl/analog_keypad_decoder_top.sv
// analog keypad decoder: apb registers, hold-off check and bit-serial divider
// a request that decodes runs the bit-serial divider over every dividend bit, then a finish step
// writes the output register; not connected or held requests go straight to the finish step.
// a new request is taken only when idle, so the input stalls until the last one leaves the finish
// step; a stalled output register holds the finish step and the input.
// reset: async active low; clears registers to their defaults, held button and change time to 0.
`include "analog_keypad_decoder_top_defines.svh"

module analog_keypad_decoder_top
    import akd_pkg::*;
(
    input  logic                   clk,
    input  logic                   rst_n,
    // configuration port
    input  logic                   psel,
    input  logic                   penable,
    input  logic                   pwrite,
    input  logic [ADDR_W-1:0]      paddr,
    input  logic [DATA_W-1:0]      pwdata,
    output logic [DATA_W-1:0]      prdata,
    output logic                   pready,
    // request channel
    input  logic                   in_valid,
    output logic                   in_stall,
    input  logic [TIME_W-1:0]      now_ms,
    input  logic [SAMPLE_BITS-1:0] adc_sample,
    // result channel
    output logic                   out_valid,
    input  logic                   out_stall,
    output logic [BUTTON_W-1:0]    button
);

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_DIV  = 2'd1;
    localparam logic [1:0] ST_FIN  = 2'd2;

    logic                   connected_reg;
    logic [STEP_W-1:0]      step_reg;
    logic [BUTTON_W-1:0]    count_reg;
    logic [HOLD_W-1:0]      holdoff_reg;

    logic [1:0]             state_reg, state_next;
    logic [CNT_W-1:0]       cnt_reg, cnt_next;
    logic [DIVIDEND_W-1:0]  dvd_reg, dvd_next;
    logic [STEP_W-1:0]      rem_reg, rem_next;
    logic                   decode_reg, decode_next;
    logic [BUTTON_W-1:0]    res_reg, res_next;
    logic [TIME_W-1:0]      now_reg, now_next;

    logic [BUTTON_W-1:0]    held_reg, held_next;
    logic [TIME_W-1:0]      change_reg, change_next;

    logic                   out_valid_reg, out_valid_next;
    logic [BUTTON_W-1:0]    button_reg, button_next;

    logic                   cfg_write;
    logic [REG_IDX_W-1:0]   cfg_idx;
    logic                   accept;
    logic                   out_free;
    logic [TIME_W-1:0]      elapsed;
    logic                   hold;
    logic [STEP_W:0]        shifted;
    logic [STEP_W+1:0]      diff;
    logic                   qbit;
    logic [DIVIDEND_W:0]    code_wide;
    logic [BUTTON_W-1:0]    code;

    // configuration write and read
    assign pready    = 1'b1;
    assign cfg_idx   = paddr[ADDR_W-1:2];
    assign cfg_write = psel && penable && pwrite && pready;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            connected_reg <= 1'b0;
            step_reg      <= STEP_RESET;
            count_reg     <= '0;
            holdoff_reg   <= HOLDOFF_RESET;
        end
        else if (cfg_write)
        begin
            case (cfg_idx)
                REG_CONNECTED: connected_reg <= pwdata[0];
                REG_STEP:      step_reg      <= pwdata[STEP_W-1:0];
                REG_COUNT:     count_reg     <= pwdata[BUTTON_W-1:0];
                REG_HOLDOFF:   holdoff_reg   <= pwdata[HOLD_W-1:0];
                default:       ;
            endcase
        end
    end

    always_comb
    begin
        case (cfg_idx)
            REG_CONNECTED: prdata = {{(DATA_W-1){1'b0}}, connected_reg};
            REG_STEP:      prdata = {{(DATA_W-STEP_W){1'b0}}, step_reg};
            REG_COUNT:     prdata = {{(DATA_W-BUTTON_W){1'b0}}, count_reg};
            REG_HOLDOFF:   prdata = {{(DATA_W-HOLD_W){1'b0}}, holdoff_reg};
            default:       prdata = '0;
        endcase
    end

    // request handshake and hold-off check
    assign in_stall = (state_reg != ST_IDLE);
    assign accept   = in_valid && !in_stall;
    assign elapsed  = now_ms - change_reg;
    assign hold     = (elapsed < {{(TIME_W-HOLD_W){1'b0}}, holdoff_reg});

    // one restoring divide step
    assign shifted = {rem_reg, dvd_reg[DIVIDEND_W-1]};
    assign diff    = {1'b0, shifted} - {2'b00, step_reg};
    assign qbit    = !diff[STEP_W+1];

    // code from quotient, zero step or too large means no press
    assign code_wide = {1'b0, dvd_reg} + {{DIVIDEND_W{1'b0}}, 1'b1};
    assign code = ((step_reg == '0) ||
                   (code_wide > {{(DIVIDEND_W+1-BUTTON_W){1'b0}}, count_reg}))
                  ? '0 : code_wide[BUTTON_W-1:0];

    assign out_free = !out_valid_reg || !out_stall;

    // sequencer and datapath
    always_comb
    begin
        state_next     = state_reg;
        cnt_next       = cnt_reg;
        dvd_next       = dvd_reg;
        rem_next       = rem_reg;
        decode_next    = decode_reg;
        res_next       = res_reg;
        now_next       = now_reg;
        held_next      = held_reg;
        change_next    = change_reg;
        out_valid_next = out_valid_reg && out_stall;
        button_next    = button_reg;
        case (state_reg)
            ST_IDLE:
            begin
                if (accept)
                begin
                    now_next = now_ms;
                    dvd_next = {{(DIVIDEND_W-SAMPLE_BITS){1'b0}}, adc_sample}
                             + {{(DIVIDEND_W-STEP_W+1){1'b0}}, step_reg[STEP_W-1:1]};
                    rem_next = '0;
                    cnt_next = DIVIDEND_W[CNT_W-1:0];
                    if (!connected_reg)
                    begin
                        decode_next = 1'b0;
                        res_next    = '0;
                        state_next  = ST_FIN;
                    end
                    else if (hold)
                    begin
                        decode_next = 1'b0;
                        res_next    = held_reg;
                        state_next  = ST_FIN;
                    end
                    else
                    begin
                        decode_next = 1'b1;
                        state_next  = ST_DIV;
                    end
                end
            end
            ST_DIV:
            begin
                rem_next = qbit ? diff[STEP_W-1:0] : shifted[STEP_W-1:0];
                dvd_next = {dvd_reg[DIVIDEND_W-2:0], qbit};
                cnt_next = cnt_reg - 1'b1;
                if (cnt_reg == {{(CNT_W-1){1'b0}}, 1'b1})
                begin
                    state_next = ST_FIN;
                end
            end
            ST_FIN:
            begin
                if (out_free)
                begin
                    out_valid_next = 1'b1;
                    button_next    = decode_reg ? code : res_reg;
                    if (decode_reg && (code != held_reg))
                    begin
                        held_next   = code;
                        change_next = now_reg;
                    end
                    state_next = ST_IDLE;
                end
            end
            default:
            begin
                state_next = ST_IDLE;
            end
        endcase
    end

    // control and state registers
    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= ST_IDLE;
            cnt_reg       <= '0;
            decode_reg    <= 1'b0;
            held_reg      <= '0;
            change_reg    <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            cnt_reg       <= cnt_next;
            decode_reg    <= decode_next;
            held_reg      <= held_next;
            change_reg    <= change_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers
    always_ff @(posedge clk)
    begin
        dvd_reg    <= dvd_next;
        rem_reg    <= rem_next;
        res_reg    <= res_next;
        now_reg    <= now_next;
        button_reg <= button_next;
    end

    assign out_valid = out_valid_reg;
    assign button    = button_reg;

    // checks
    `AKD_ASSERT_NEXT(a_unconnected_zero, accept && !connected_reg,
        (state_reg == ST_FIN) && (res_reg == '0) && !decode_reg,
        "unconnected request did not yield a zero result")
    `AKD_ASSERT_NEXT(a_fin_loads_output, (state_reg == ST_FIN) && !out_valid_reg,
        out_valid_reg && (state_reg == ST_IDLE),
        "finished request did not reach the free output register")
    `AKD_ASSERT_SAME(a_held_changes_on_fin, !$stable(held_reg),
        $past(state_reg) == ST_FIN,
        "held button changed outside the finish step")

endmodule
